// ===== hdl/grw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grw_pkg: shared types and constants for the graph reachability walk
// Opcodes, widths and the command record passed from front to back.
// ----------------------------------------------------------------------------
package grw_pkg;
  localparam int NODE_COUNT = 256;
  localparam int EDGE_COUNT = 1024;
  localparam int NW = $clog2(NODE_COUNT);
  localparam int EW = $clog2(EDGE_COUNT);

  localparam logic [1:0] OP_CLEAR    = 2'd0;
  localparam logic [1:0] OP_ADD      = 2'd1;
  localparam logic [1:0] OP_TRAVERSE = 2'd2;
  localparam logic [1:0] OP_QUERY    = 2'd3;

  typedef struct packed {
    logic [1:0]    opcode;
    logic [NW-1:0] node_a;
    logic [NW-1:0] node_b;
    logic          walk_mode;
  } cmd_t;

  typedef struct packed {
    logic          status;
    logic          reachable;
    logic [7:0]    hop_distance;
    logic [7:0]    parent_node;
    logic [8:0]    reached_count;
  } rsp_t;
endpackage

// ===== hdl/grw_cmd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grw_cmd_queue: front end command queue
// Accepts input items and holds up to four decoded commands for the engine.
// ----------------------------------------------------------------------------
module grw_cmd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  grw_pkg::cmd_t in_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output grw_pkg::cmd_t out_cmd
);
  grw_pkg::cmd_t slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;
  logic       push;
  logic       pop;

  assign in_ready  = (fill != 3'd4);
  assign out_valid = (fill != 3'd0);
  assign out_cmd   = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_cmd;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + {2'b0, push} - {2'b0, pop};
    end
  end
endmodule

// ===== hdl/grw_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grw_engine: back end graph engine
// Edge store, adjacency lists, traversal sequencer and result register.
// ----------------------------------------------------------------------------
module grw_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  grw_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output grw_pkg::rsp_t rsp
);
  localparam int NW = grw_pkg::NW;
  localparam int EW = grw_pkg::EW;
  localparam logic [NW:0] NODE_ONE = {{NW{1'b0}}, 1'b1};
  localparam logic [EW:0] EDGE_ONE = {{EW{1'b0}}, 1'b1};

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ADD    = 4'd1;
  localparam logic [3:0] S_QRD    = 4'd2;
  localparam logic [3:0] S_QOUT   = 4'd3;
  localparam logic [3:0] S_POP    = 4'd4;
  localparam logic [3:0] S_POPRD  = 4'd5;
  localparam logic [3:0] S_NODE   = 4'd6;
  localparam logic [3:0] S_EDGE   = 4'd7;
  localparam logic [3:0] S_EDGERD = 4'd8;
  localparam logic [3:0] S_VISIT  = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;
  localparam logic [3:0] S_CLRV   = 4'd11;
  localparam logic [3:0] S_ADDRD  = 4'd12;
  localparam logic [3:0] S_POPWT  = 4'd13;

  // memories
  logic [NW-1:0] edge_dest  [grw_pkg::EDGE_COUNT];
  logic [EW-1:0] edge_link  [grw_pkg::EDGE_COUNT];
  logic [EW-1:0] list_first [grw_pkg::NODE_COUNT];
  logic [EW-1:0] list_last  [grw_pkg::NODE_COUNT];
  logic [7:0]    node_dist  [grw_pkg::NODE_COUNT];
  logic [NW-1:0] node_par   [grw_pkg::NODE_COUNT];
  logic [NW-1:0] pending    [grw_pkg::NODE_COUNT];
  // flag arrays, cleared at once
  logic [grw_pkg::NODE_COUNT-1:0] list_present;
  logic [grw_pkg::NODE_COUNT-1:0] in_graph;
  logic [grw_pkg::NODE_COUNT-1:0] visited;

  logic [3:0]    state;
  grw_pkg::cmd_t cur_cmd;
  logic [EW:0]   edge_total;
  logic [NW:0]   head;
  logic [NW:0]   tail;
  logic [8:0]    count;
  logic [NW-1:0] cur;
  logic [7:0]    cur_dist;
  logic [EW-1:0] e;
  logic [EW-1:0] e_last;
  logic [EW-1:0] link_rd;
  logic [EW-1:0] first_rd;
  logic [EW-1:0] last_rd;
  logic [EW-1:0] add_last_rd;
  logic [7:0]    dist_rd;
  logic [NW-1:0] par_rd;
  logic [NW-1:0] pend_rd;
  logic [NW-1:0] dest_rd;
  logic          clr_pend;

  assign cmd_ready = (state == S_IDLE) && !rsp_valid;

  // registered memory reads
  always_ff @(posedge clk) begin
    first_rd    <= list_first[cur];
    last_rd     <= list_last[cur];
    add_last_rd <= list_last[cur_cmd.node_a];
    dist_rd     <= node_dist[cur_cmd.node_a];
    par_rd      <= node_par[cur_cmd.node_a];
    pend_rd     <= pending[head[NW-1:0]];
    dest_rd     <= edge_dest[e];
    link_rd     <= edge_link[e];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rsp_valid    <= 1'b0;
      edge_total   <= '0;
      list_present <= '0;
      in_graph     <= '0;
      visited      <= '0;
      clr_pend     <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            cur_cmd <= cmd;
            rsp     <= '0;
            unique case (cmd.opcode)
              grw_pkg::OP_CLEAR: begin
                list_present <= '0;
                in_graph     <= '0;
                visited      <= '0;
                edge_total   <= '0;
                rsp_valid    <= 1'b1;
              end
              grw_pkg::OP_ADD: begin
                if (edge_total[EW]) begin
                  rsp.status <= 1'b1;
                  rsp_valid  <= 1'b1;
                end else begin
                  state <= S_ADDRD;
                end
              end
              grw_pkg::OP_TRAVERSE: begin
                visited <= '0;
                state   <= S_CLRV;
              end
              default: state <= S_QRD;
            endcase
          end
        end
        // tail of the source list is read this cycle
        S_ADDRD: state <= S_ADD;
        S_ADD: begin
          edge_dest[edge_total[EW-1:0]] <= cur_cmd.node_b;
          if (list_present[cur_cmd.node_a]) begin
            edge_link[add_last_rd] <= edge_total[EW-1:0];
          end else begin
            list_first[cur_cmd.node_a] <= edge_total[EW-1:0];
          end
          list_last[cur_cmd.node_a]    <= edge_total[EW-1:0];
          list_present[cur_cmd.node_a] <= 1'b1;
          in_graph[cur_cmd.node_a]     <= 1'b1;
          in_graph[cur_cmd.node_b]     <= 1'b1;
          edge_total <= edge_total + EDGE_ONE;
          rsp_valid  <= 1'b1;
          state      <= S_IDLE;
        end
        S_QRD: state <= S_QOUT;
        S_QOUT: begin
          if (in_graph[cur_cmd.node_a] && visited[cur_cmd.node_a]) begin
            rsp.reachable    <= 1'b1;
            rsp.hop_distance <= dist_rd;
            rsp.parent_node  <= par_rd;
          end
          rsp_valid <= 1'b1;
          state     <= S_IDLE;
        end
        S_CLRV: begin
          visited[cur_cmd.node_a]  <= 1'b1;
          node_par[cur_cmd.node_a] <= cur_cmd.node_a;
          node_dist[cur_cmd.node_a] <= 8'd0;
          pending[0] <= cur_cmd.node_a;
          head  <= '0;
          tail  <= NODE_ONE;
          count <= 9'd1;
          state <= S_POP;
        end
        S_POP: begin
          if (head == tail) begin
            state <= S_DONE;
          end else if (cur_cmd.walk_mode) begin
            // stack: read top, reuse head as the read address
            head  <= tail - NODE_ONE;
            tail  <= tail - NODE_ONE;
            clr_pend <= 1'b1;
            state <= S_POPWT;
          end else begin
            head  <= head;
            state <= S_POPRD;
          end
        end
        // new head address is read this cycle
        S_POPWT: state <= S_POPRD;
        S_POPRD: begin
          cur <= pend_rd;
          if (clr_pend) begin
            head     <= '0;
            clr_pend <= 1'b0;
          end else begin
            head <= head + NODE_ONE;
          end
          state <= S_NODE;
        end
        S_NODE: begin
          // list_first/last and distance of cur available next cycle
          cur_dist <= node_dist[cur];
          if (!list_present[cur]) state <= S_POP;
          else                    state <= S_EDGE;
        end
        S_EDGE: begin
          e      <= first_rd;
          e_last <= last_rd;
          state  <= S_EDGERD;
        end
        S_EDGERD: state <= S_VISIT;
        S_VISIT: begin
          if (!visited[dest_rd] && !tail[NW]) begin
            visited[dest_rd]   <= 1'b1;
            node_par[dest_rd]  <= cur;
            node_dist[dest_rd] <= (cur_dist == 8'd255) ? 8'd255 : cur_dist + 8'd1;
            pending[tail[NW-1:0]] <= dest_rd;
            tail  <= tail + NODE_ONE;
            count <= count + 9'd1;
          end
          if (e == e_last) begin
            state <= S_POP;
          end else begin
            e     <= link_rd;
            state <= S_EDGERD;
          end
        end
        S_DONE: begin
          rsp.reached_count <= count;
          rsp_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/graph_reachability_walk_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_reachability_walk_core: single-source reachability over a graph
// Loads a directed graph edge by edge and walks it breadth-first or by stack.
// ----------------------------------------------------------------------------
// Usage: s_axis carries one command item (clear, add edge, traverse, query),
// with the opcode in tuser; m_axis returns exactly one result item per
// command, in order. A four-entry command queue decouples intake from the
// graph engine, so items are taken while the engine works or a result waits.
// The time of a traverse grows with each reached node (more in stack mode,
// less for a node with no out edges) and with each edge scanned, set by
// the registered memory reads of the list walk, plus setup and finish;
// an add finishes sooner when the edge store is full. The engine runs one
// command at a time and starts the next only after its result is taken.
// Reset clears the edge count, list, graph and visited flags; the
// memories need no clearing pass. When m_axis stalls, the result is held
// and the engine waits; the queue keeps accepting until it fills.
// ----------------------------------------------------------------------------
module graph_reachability_walk_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] node_a, [15:8] node_b, [16] walk_mode, zero fill
  input  logic [23:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] status, [1] reachable, [9:2] hop_distance, [17:10] parent_node,
  // [26:18] reached_count, zero fill
  output logic [31:0] m_axis_tdata
);
  grw_pkg::cmd_t in_cmd;
  grw_pkg::cmd_t q_cmd;
  grw_pkg::rsp_t rsp;
  logic          q_valid;
  logic          q_ready;

  assign in_cmd.opcode    = s_axis_tuser;
  assign in_cmd.node_a    = s_axis_tdata[7:0];
  assign in_cmd.node_b    = s_axis_tdata[15:8];
  assign in_cmd.walk_mode = s_axis_tdata[16];

  grw_cmd_queue u_queue (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
    .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
  );

  grw_engine u_engine (
    .clk(clk), .rst(rst),
    .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
    .rsp_valid(m_axis_tvalid), .rsp_ready(m_axis_tready), .rsp(rsp)
  );

  assign m_axis_tdata = {5'd0, rsp.reached_count, rsp.parent_node,
                         rsp.hop_distance, rsp.reachable, rsp.status};
endmodule
